// File: hdl/pfx_pkg.sv
// Shared types, codes and sizes for the pixel format to XRGB32 converter.
`default_nettype none

package pfx_pkg;

    // Source formats held in the colour format register
    localparam logic [2:0] FMT_XRGB32   = 3'd0;
    localparam logic [2:0] FMT_RGB565   = 3'd1;
    localparam logic [2:0] FMT_XRGB1555 = 3'd2;
    localparam logic [2:0] FMT_ARGB4444 = 3'd3;
    localparam logic [2:0] FMT_RGB332   = 3'd4;
    localparam logic [2:0] FMT_PALETTE8 = 3'd5;
    localparam logic [2:0] FMT_GRAY4    = 3'd6;
    localparam logic [2:0] FMT_MONO     = 3'd7;

    // Input item kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_PAL_WR = 1'b1;

    // Operations passed from the front end to the back end
    localparam logic [1:0] OP_PIXEL  = 2'd0;
    localparam logic [1:0] OP_PAL_RD = 2'd1;
    localparam logic [1:0] OP_PACKED = 2'd2;
    localparam logic [1:0] OP_PAL_WR = 2'd3;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int CMD_DEPTH           = 4;
    localparam int OUT_DEPTH           = 4;
    localparam int CMD_LW              = $clog2(CMD_DEPTH + 1);
    localparam int OUT_LW              = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [31:0] data;
        logic [2:0]  start_position;
        logic [3:0]  pixel_count;
        logic [7:0]  palette_index;
    } pfx_in_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        last;
    } pfx_out_t;

    // Classified operation: data is the finished pixel, the palette word or the packed byte
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] data;
        logic [7:0]  idx;
        logic        gray;
        logic [2:0]  start;
        logic [3:0]  count;
    } pfx_cmd_t;

endpackage

`default_nettype wire

// File: hdl/pfx_fifo.sv
// Small show-ahead register queue used between and after the converter stages.
`default_nettype none

module pfx_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 4
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        push,
    input  item_t                      wdata,
    input  wire                        pop,
    output item_t                      rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    item_t          slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]  level_reg, level_next;
    logic           do_push;
    logic           do_pop;

    assign do_push = push && (level_reg != LW'(DEPTH));
    assign do_pop  = pop && (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        level_next = level_reg + LW'(do_push) - LW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

    // Both users hold back their push while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg != LW'(DEPTH)))
        else $error("pfx_fifo: push while full");

endmodule

`default_nettype wire

// File: hdl/pfx_front.sv
// Front end: holds the format register, accepts items and classifies them into operations.
`default_nettype none

module pfx_front (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire  [2:0]                     cfg_data,
    input  wire                            push,
    input  pfx_pkg::pfx_in_t               item,
    output logic                           full,
    input  wire  [pfx_pkg::CMD_LW-1:0]     cmd_level,
    output logic                           cmd_push,
    output pfx_pkg::pfx_cmd_t              cmd
);

    import pfx_pkg::*;

    logic [2:0]  color_format_reg;
    logic        accept;
    logic        drop;
    logic [31:0] direct_pixel;
    logic [3:0]  per_byte;
    logic [3:0]  avail;
    logic [3:0]  clipped;

    function automatic logic [7:0] fill5(input logic [4:0] f);
        fill5 = {f, {3{f[0]}}};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_format_reg <= FMT_XRGB32;
        end
        else if (cfg_we)
        begin
            color_format_reg <= cfg_data;
        end
    end

    // Direct conversion of one source word
    always_comb
    begin
        unique case (color_format_reg)
            FMT_RGB565:
            begin
                direct_pixel = {8'hff, fill5(item.data[15:11]),
                                item.data[10:5], {2{item.data[5]}},
                                fill5(item.data[4:0])};
            end
            FMT_XRGB1555:
            begin
                direct_pixel = {8'hff, fill5(item.data[14:10]), fill5(item.data[9:5]),
                                fill5(item.data[4:0])};
            end
            FMT_ARGB4444:
            begin
                direct_pixel = {8'hff, {2{item.data[11:8]}}, {2{item.data[7:4]}},
                                {2{item.data[3:0]}}};
            end
            FMT_RGB332:
            begin
                direct_pixel = {8'hff, item.data[7:5], {5{item.data[5]}},
                                item.data[4:2], {5{item.data[2]}},
                                item.data[1:0], {6{item.data[0]}}};
            end
            default:
            begin
                direct_pixel = item.data;
            end
        endcase
    end

    // Clip the packed run to the sub-pixels left in the byte
    always_comb
    begin
        per_byte = (color_format_reg == FMT_GRAY4) ? 4'd2 : 4'd8;
        avail    = per_byte - {1'b0, item.start_position};
        clipped  = (item.pixel_count < avail) ? item.pixel_count : avail;
    end

    always_comb
    begin
        cmd.data  = direct_pixel;
        cmd.idx   = item.data[7:0];
        cmd.gray  = (color_format_reg == FMT_GRAY4);
        cmd.start = item.start_position;
        cmd.count = clipped;
        drop      = 1'b0;
        if (item.kind == KIND_PAL_WR)
        begin
            cmd.op   = OP_PAL_WR;
            cmd.data = item.data;
            cmd.idx  = item.palette_index;
        end
        else
        begin
            case (color_format_reg) inside
                FMT_PALETTE8:
                begin
                    cmd.op = OP_PAL_RD;
                end
                FMT_GRAY4, FMT_MONO:
                begin
                    cmd.op   = OP_PACKED;
                    cmd.data = {24'd0, item.data[7:0]};
                    drop     = ({1'b0, item.start_position} >= per_byte)
                               || (item.pixel_count == 4'd0);
                end
                default:
                begin
                    cmd.op = OP_PIXEL;
                end
            endcase
        end
    end

    assign full     = (cmd_level == CMD_LW'(CMD_DEPTH));
    assign accept   = push && !full;
    assign cmd_push = accept && !drop;

endmodule

`default_nettype wire

// File: hdl/pfx_back.sv
// Back end: palette memory, packed-byte unpacker and result register feeding the output queue.
`default_nettype none

module pfx_back #(
    parameter int PALETTE_ENTRIES = pfx_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cmd_valid,
    input  pfx_pkg::pfx_cmd_t              cmd,
    output logic                           cmd_pop,
    input  wire  [pfx_pkg::OUT_LW-1:0]     out_level,
    output logic                           res_push,
    output pfx_pkg::pfx_out_t              res
);

    import pfx_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [31:0]   pal_mem [PALETTE_ENTRIES];
    logic [31:0]   rd_data_reg;

    logic          pk_active_reg, pk_active_next;
    logic [2:0]    pk_pos_reg, pk_pos_next;
    logic [3:0]    pk_left_reg, pk_left_next;

    logic          b_valid_reg, b_valid_next;
    logic          b_pal_reg, b_pal_next;
    logic          b_zero_reg, b_zero_next;
    logic [31:0]   b_pixel_reg, b_pixel_next;
    logic          b_last_reg, b_last_next;

    logic          credit;
    logic          in_range;
    logic          pal_wr;
    logic          pal_rd;
    logic [2:0]    cur_pos;
    logic [3:0]    cur_left;
    logic [3:0]    nib;
    logic [31:0]   packed_pixel;

    // Room in the output queue for one more result, counting the one in flight
    assign credit   = ({1'b0, out_level} + (OUT_LW + 1)'(b_valid_reg))
                      < (OUT_LW + 1)'(OUT_DEPTH);
    assign in_range = (32'(cmd.idx) < PALETTE_ENTRIES);

    assign cur_pos  = pk_active_reg ? pk_pos_reg : cmd.start;
    assign cur_left = pk_active_reg ? pk_left_reg : cmd.count;

    always_comb
    begin
        nib = (cur_pos == 3'd0) ? cmd.data[7:4] : cmd.data[3:0];
        if (cmd.gray)
        begin
            packed_pixel = {8'hff, {6{nib}}};
        end
        else
        begin
            packed_pixel = {32{cmd.data[~cur_pos]}};
        end
    end

    always_comb
    begin
        cmd_pop        = 1'b0;
        pal_wr         = 1'b0;
        pal_rd         = 1'b0;
        pk_active_next = pk_active_reg;
        pk_pos_next    = pk_pos_reg;
        pk_left_next   = pk_left_reg;
        b_valid_next   = 1'b0;
        b_pal_next     = 1'b0;
        b_zero_next    = 1'b0;
        b_pixel_next   = cmd.data;
        b_last_next    = 1'b1;
        if (cmd_valid)
        begin
            unique case (cmd.op)
                OP_PAL_WR:
                begin
                    pal_wr  = in_range;
                    cmd_pop = 1'b1;
                end
                OP_PAL_RD:
                begin
                    if (credit)
                    begin
                        pal_rd       = in_range;
                        cmd_pop      = 1'b1;
                        b_valid_next = 1'b1;
                        b_pal_next   = 1'b1;
                        b_zero_next  = !in_range;
                    end
                end
                OP_PACKED:
                begin
                    if (credit)
                    begin
                        b_valid_next = 1'b1;
                        b_pixel_next = packed_pixel;
                        b_last_next  = (cur_left == 4'd1);
                        if (cur_left == 4'd1)
                        begin
                            cmd_pop        = 1'b1;
                            pk_active_next = 1'b0;
                        end
                        else
                        begin
                            pk_active_next = 1'b1;
                            pk_pos_next    = cur_pos + 3'd1;
                            pk_left_next   = cur_left - 4'd1;
                        end
                    end
                end
                default:
                begin
                    if (credit)
                    begin
                        cmd_pop      = 1'b1;
                        b_valid_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_active_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            pk_active_reg <= pk_active_next;
            b_valid_reg   <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pk_pos_reg  <= pk_pos_next;
        pk_left_reg <= pk_left_next;
        b_pal_reg   <= b_pal_next;
        b_zero_reg  <= b_zero_next;
        b_pixel_reg <= b_pixel_next;
        b_last_reg  <= b_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (pal_wr)
        begin
            pal_mem[cmd.idx[AW-1:0]] <= cmd.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_rd)
        begin
            rd_data_reg <= pal_mem[cmd.idx[AW-1:0]];
        end
    end

    assign res_push      = b_valid_reg;
    assign res.pixel_out = !b_pal_reg ? b_pixel_reg : (b_zero_reg ? 32'd0 : rd_data_reg);
    assign res.last      = b_last_reg;

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (out_level < OUT_LW'(OUT_DEPTH)))
        else $error("pfx_back: result issued without room in output queue");

    a_pack_head: assert property (@(posedge clk) disable iff (!rst_n)
        pk_active_reg |-> (cmd_valid && (cmd.op == OP_PACKED)))
        else $error("pfx_back: unpacking without a packed operation at the head");

    a_pack_left: assert property (@(posedge clk) disable iff (!rst_n)
        pk_active_reg |-> (pk_left_reg != 4'd0))
        else $error("pfx_back: unpacker active with nothing left");

endmodule

`default_nettype wire

// File: hdl/pixel_format_to_xrgb32_top.sv
// Path: an accepted item goes through the operation queue and the back-end result register.
// Throughput: one item per cycle for direct, palette and palette-write items unless a queue
//   is full; a packed gray or mono byte emits one pixel per cycle while the output queue has room.
// Reset: rst_n asynchronous, active low; clears queues, unpacker and the format register
//   (xrgb32). Palette contents are undefined until written.
`default_nettype none

module pixel_format_to_xrgb32_top #(
    parameter int PALETTE_ENTRIES = pfx_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    // configuration: colour format register
    input  wire                 cfg_we,
    input  wire  [2:0]          cfg_data,
    // source side
    input  wire                 push,
    input  pfx_pkg::pfx_in_t    item,
    output logic                full,
    // result side
    output logic                empty,
    input  wire                 pop,
    output pfx_pkg::pfx_out_t   result
);

    import pfx_pkg::*;

    // Front end to back end: classified operations
    logic              cmd_push;
    pfx_cmd_t          cmd_wdata;
    pfx_cmd_t          cmd_head;
    logic              cmd_empty;
    logic              cmd_pop;
    logic [CMD_LW-1:0] cmd_level;

    // Back end to output queue
    logic              res_push;
    pfx_out_t          res_wdata;
    logic [OUT_LW-1:0] out_level;

    // Accept and classify; a transaction is taken whenever the operation queue has room
    pfx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_level (cmd_level),
        .cmd_push  (cmd_push),
        .cmd       (cmd_wdata)
    );

    // Short queue decoupling classification from execution
    pfx_fifo #(
        .item_t (pfx_cmd_t),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .rdata (cmd_head),
        .empty (cmd_empty),
        .level (cmd_level)
    );

    // Execute: palette access, unpacking, result register
    pfx_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .out_level (out_level),
        .res_push  (res_push),
        .res       (res_wdata)
    );

    // Output queue: holds results while the consumer stalls; the back end runs on until it has no room
    pfx_fifo #(
        .item_t (pfx_out_t),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .pop   (pop),
        .rdata (result),
        .empty (empty),
        .level (out_level)
    );

endmodule

`default_nettype wire

// File: sim/pixel_format_checker.sv
// Checker for the XRGB32 converter: predicts the pixel stream and compares every result transaction.
`timescale 1ns / 100ps

module pixel_format_checker #(
    parameter int PALETTE_ENTRIES = pfx_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire  [2:0]         cfg_data,
    input  wire                push,
    input  pfx_pkg::pfx_in_t   item,
    input  wire                full,
    input  wire                empty,
    input  wire                pop,
    input  pfx_pkg::pfx_out_t  result,
    output int                 failures,
    output int                 pending,
    output int                 checked
);

    import pfx_pkg::*;

    logic [2:0]  format_shadow;
    logic [31:0] palette_shadow [PALETTE_ENTRIES];
    pfx_out_t    expected_pixels [$];
    int          fail_count;
    int          seen_count;

    function automatic logic [31:0] direct_pixel(logic [2:0] fmt, logic [31:0] d);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] idx;
        r   = '0;
        g   = '0;
        b   = '0;
        idx = d[7:0];
        case (fmt)
            FMT_XRGB32:
                return d;
            FMT_RGB565:
            begin
                r = {d[15:11], {3{d[11]}}};
                g = {d[10:5], {2{d[5]}}};
                b = {d[4:0], {3{d[0]}}};
            end
            FMT_XRGB1555:
            begin
                r = {d[14:10], {3{d[10]}}};
                g = {d[9:5], {3{d[5]}}};
                b = {d[4:0], {3{d[0]}}};
            end
            FMT_ARGB4444:
            begin
                r = {d[11:8], d[11:8]};
                g = {d[7:4], d[7:4]};
                b = {d[3:0], d[3:0]};
            end
            FMT_RGB332:
            begin
                r = {d[7:5], {5{d[5]}}};
                g = {d[4:2], {5{d[2]}}};
                b = {d[1:0], {6{d[0]}}};
            end
            default:
                return (int'(idx) < PALETTE_ENTRIES) ? palette_shadow[idx] : 32'h0;
        endcase
        return {8'hff, r, g, b};
    endfunction

    // Queue the pixels one input transaction gives rise to; apply palette loads.
    task automatic expand_item(pfx_in_t it);
        int         per_byte;
        int         n;
        int         pos;
        logic [3:0] nib;
        pfx_out_t   px;
        if (it.kind == KIND_PAL_WR)
        begin
            if (int'(it.palette_index) < PALETTE_ENTRIES)
                palette_shadow[it.palette_index] = it.data;
        end
        else if (format_shadow != FMT_GRAY4 && format_shadow != FMT_MONO)
        begin
            px.pixel_out = direct_pixel(format_shadow, it.data);
            px.last      = 1'b1;
            expected_pixels.push_back(px);
        end
        else
        begin
            per_byte = (format_shadow == FMT_GRAY4) ? 2 : 8;
            if (int'(it.start_position) < per_byte)
            begin
                n = per_byte - int'(it.start_position);
                if (int'(it.pixel_count) < n)
                    n = int'(it.pixel_count);
                for (int k = 0; k < n; k++)
                begin
                    pos = int'(it.start_position) + k;
                    if (format_shadow == FMT_GRAY4)
                    begin
                        nib = (pos == 0) ? it.data[7:4] : it.data[3:0];
                        px.pixel_out = {8'hff, {3{nib, nib}}};
                    end
                    else
                        px.pixel_out = it.data[7 - pos] ? 32'hffff_ffff : 32'h0;
                    px.last = (k == n - 1);
                    expected_pixels.push_back(px);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_shadow = FMT_XRGB32;
            expected_pixels.delete();
            fail_count    = 0;
            seen_count    = 0;
            failures <= 0;
            pending  <= 0;
            checked  <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                seen_count++;
                if (expected_pixels.size() == 0)
                begin
                    $error("result transaction with nothing expected: pixel_out %h last %b",
                           result.pixel_out, result.last);
                    fail_count++;
                end
                else
                begin
                    pfx_out_t want;
                    want = expected_pixels.pop_front();
                    if (result.pixel_out !== want.pixel_out)
                    begin
                        $error("pixel_out mismatch: expected %h, actual %h",
                               want.pixel_out, result.pixel_out);
                        fail_count++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last mismatch: expected %b, actual %b", want.last, result.last);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                expand_item(item);
            if (cfg_we)
                format_shadow = cfg_data;
            failures <= fail_count;
            pending  <= expected_pixels.size();
            checked  <= seen_count;
        end
    end

endmodule

// File: sim/tb_pixel_format_to_xrgb32_top.sv
// Testbench top for the XRGB32 converter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_pixel_format_to_xrgb32_top;
    import pfx_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    logic [2:0] cfg_data;
    logic     push;
    pfx_in_t  item;
    logic     full;
    logic     empty;
    logic     pop;
    pfx_out_t result;

    int failures;
    int pending;
    int checked;

    // Flow control knobs, set by the stimulus and read by it and the receiver process
    int tx_max_gap  = 19;
    int rx_max_gap  = 19;
    int rx_holdoff  = 0;

    // Palette entries loaded so far; palette reads only ever target these
    bit         pal_loaded [256];
    logic [7:0] loaded_idx [$];
    int         items_sent = 0;
    bit [7:0]   formats_seen = '0;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pixel_format_to_xrgb32_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .item     (item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    pixel_format_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .item     (item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .failures (failures),
        .pending  (pending),
        .checked  (checked)
    );

    function automatic pfx_in_t mk_item(logic kind, logic [31:0] data, logic [2:0] start,
                                        logic [3:0] count, logic [7:0] idx);
        pfx_in_t it;
        it.kind           = kind;
        it.data           = data;
        it.start_position = start;
        it.pixel_count    = count;
        it.palette_index  = idx;
        return it;
    endfunction

    // Draw one random transaction for the current format. Mostly pixel data with
    // sensible packing positions, with some palette loads and some clipped or
    // empty packed requests mixed in.
    function automatic pfx_in_t roll_item(logic [2:0] fmt);
        pfx_in_t it;
        int      roll;
        it.kind           = KIND_PIXEL;
        it.data           = $urandom;
        it.start_position = 3'($urandom_range(0, 7));
        it.pixel_count    = 4'($urandom_range(0, 15));
        it.palette_index  = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 15)
            it.kind = KIND_PAL_WR;
        else if (fmt == FMT_PALETTE8)
            it.data[7:0] = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
        else if (fmt == FMT_GRAY4 || fmt == FMT_MONO)
        begin
            // keep most requests inside the byte with a legal count
            if (roll < 85)
            begin
                it.pixel_count = 4'($urandom_range(1, 8));
                if (fmt == FMT_GRAY4)
                    it.start_position = 3'($urandom_range(0, 1));
            end
        end
        return it;
    endfunction

    // Offer one transaction after a random gap; hold it until the block takes it.
    task automatic send_item(pfx_in_t it);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (it.kind == KIND_PAL_WR && !pal_loaded[it.palette_index])
        begin
            pal_loaded[it.palette_index] = 1'b1;
            loaded_idx.push_back(it.palette_index);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    // Stop offering, wait for every expected pixel, then let the pipeline settle
    // so that items with no result have left it as well.
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    // Change the colour format only with the block idle.
    task automatic set_format(logic [2:0] fmt);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= fmt;
        @(posedge clk);
        cfg_we   <= 1'b0;
        formats_seen[fmt] = 1'b1;
    endtask

    // Result side: pop after a random gap, with an occasional long hold-off
    // requested by the stimulus to back the block up.
    initial
    begin
        int gap;
        int hold;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_holdoff > 0)
            begin
                hold       = rx_holdoff;
                rx_holdoff = 0;
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    // Stimulus
    initial
    begin
        logic [2:0] fmt;
        rst_n    = 1'b0;
        push     <= 1'b0;
        item     <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= FMT_XRGB32;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset format is pass-through; load the palette extremes.
        formats_seen[FMT_XRGB32] = 1'b1;
        send_item(mk_item(KIND_PIXEL, 32'h0000_0000, 3'd0, 4'd0, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'hffff_ffff, 3'd7, 4'd15, 8'hff));
        send_item(mk_item(KIND_PAL_WR, 32'hffff_ffff, 3'd0, 4'd1, 8'd255));
        send_item(mk_item(KIND_PAL_WR, 32'h0000_0000, 3'd0, 4'd1, 8'd0));
        send_item(mk_item(KIND_PAL_WR, 32'h1234_5678, 3'd0, 4'd1, 8'h5a));

        set_format(FMT_RGB565);
        send_item(mk_item(KIND_PIXEL, 32'h0000_ffff, 3'd0, 4'd1, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'hffff_0821, 3'd0, 4'd1, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'h0000_0000, 3'd0, 4'd1, 8'd0));

        // bit 15 must be ignored in 1555
        set_format(FMT_XRGB1555);
        send_item(mk_item(KIND_PIXEL, 32'h0000_8000, 3'd0, 4'd1, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'hffff_7fff, 3'd0, 4'd1, 8'd0));

        set_format(FMT_ARGB4444);
        send_item(mk_item(KIND_PIXEL, 32'h0000_0fff, 3'd0, 4'd1, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'hffff_f000, 3'd0, 4'd1, 8'd0));

        set_format(FMT_RGB332);
        send_item(mk_item(KIND_PIXEL, 32'h0000_0025, 3'd0, 4'd1, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'hffff_ffda, 3'd0, 4'd1, 8'd0));

        // read back the loaded entries, upper data bits set on the first to show they are ignored
        set_format(FMT_PALETTE8);
        send_item(mk_item(KIND_PIXEL, 32'hffff_ff00, 3'd0, 4'd1, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'h0000_00ff, 3'd0, 4'd1, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'h0000_005a, 3'd0, 4'd1, 8'd0));

        // gray: full byte, second nibble only, start past the byte, zero count
        set_format(FMT_GRAY4);
        send_item(mk_item(KIND_PIXEL, 32'h0000_00a5, 3'd0, 4'd8, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'hffff_ff3c, 3'd1, 4'd1, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'h0000_00ff, 3'd2, 4'd3, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'h0000_00ff, 3'd0, 4'd0, 8'd0));

        // mono: whole byte, clipped at the end, oversized count, zero count
        set_format(FMT_MONO);
        send_item(mk_item(KIND_PIXEL, 32'h0000_0096, 3'd0, 4'd8, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'h0000_0001, 3'd7, 4'd8, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'hffff_ff5b, 3'd3, 4'd15, 8'd0));
        send_item(mk_item(KIND_PIXEL, 32'h0000_00ff, 3'd5, 4'd0, 8'd0));

        // Random part: twelve phases, every format visited in order first,
        // then random ones. Vary idling per phase so that some stretches run
        // flat out on one or both sides.
        for (int phase = 0; phase < 12; phase++)
        begin
            fmt = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            set_format(fmt);
            tx_max_gap = (phase % 3 == 2) ? 0 : 19;
            rx_max_gap = (phase % 4 == 1) ? 0 : 19;
            if (phase == 2)
            begin
                // hold the result side off and stream input flat out so the
                // queues fill and full asserts
                rx_holdoff = 400;
                tx_max_gap = 0;
            end
            for (int n = 0; n < 32; n++)
            begin
                send_item(roll_item(fmt));
                if (n == 15 && (phase == 5 || phase == 7))
                    drain();
            end
        end

        drain();
        $display("Sent %0d input transactions across format mask %b; checked %0d pixels.",
                 items_sent, formats_seen, checked);
        $display("Covered palette loads and reads, packed clipping and a full-queue stall.");
        if (failures == 0)
            $display("tb_pixel_format_to_xrgb32_top OK");
        else
            $display("tb_pixel_format_to_xrgb32_top NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("tb_pixel_format_to_xrgb32_top NOT OK");
        $finish;
    end

endmodule
